>>> src/peer_liveness_tracker_assert.svh
`ifndef PEER_LIVENESS_TRACKER_ASSERT_SVH
`define PEER_LIVENESS_TRACKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PLT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plt assertion failed");

// next-cycle implication, checked outside reset
`define PLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plt assertion failed");

`endif

>>> src/plt_pkg.sv
package plt_pkg;

    localparam logic [1:0] CMD_HEARTBEAT = 2'd0;
    localparam logic [1:0] CMD_REGISTER  = 2'd1;
    localparam logic [1:0] CMD_SCAN      = 2'd2;
    localparam logic [1:0] CMD_QUERY     = 2'd3;

    localparam logic [2:0] EV_JOINED  = 3'd0;
    localparam logic [2:0] EV_SUSPECT = 3'd1;
    localparam logic [2:0] EV_DEAD    = 3'd2;
    localparam logic [2:0] EV_EVICTED = 3'd3;
    localparam logic [2:0] EV_QUERY   = 3'd4;

    localparam logic [1:0] PS_ALIVE   = 2'd0;
    localparam logic [1:0] PS_SUSPECT = 2'd1;
    localparam logic [1:0] PS_DEAD    = 2'd2;

    localparam logic [2:0] CFG_LOCAL_NODE    = 3'd0;
    localparam logic [2:0] CFG_LOCAL_CLUSTER = 3'd1;
    localparam logic [2:0] CFG_SUSPECT_MS    = 3'd2;
    localparam logic [2:0] CFG_DEAD_MS       = 3'd3;
    localparam logic [2:0] CFG_EVICT_MS      = 3'd4;

    localparam logic [21:0] SUSPECT_MS_RST = 22'd1000;
    localparam logic [21:0] DEAD_MS_RST    = 22'd3000;
    localparam logic [21:0] EVICT_MS_RST   = 22'd10000;

    localparam logic [19:0] NS_PER_MS = 20'd1000000;

    typedef struct packed {
        logic [1:0]  state;
        logic [63:0] last_beat;
        logic [63:0] changed;
        logic [15:0] cluster;
        logic [31:0] endpoint;
    } slot_rec_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  index;
        logic [15:0] cluster;
        logic [1:0]  state;
        logic [63:0] time_ns;
        logic [63:0] last_beat;
        logic [63:0] changed;
        logic [31:0] endpoint;
        logic        found;
        logic        last;
    } result_t;

endpackage

>>> src/plt_ram.sv
module plt_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/peer_liveness_tracker.sv
// heartbeat, register and query: a slot read, then write-back and result
// scan: read, age and write-back per occupied slot, a read per empty slot, one more step if a slot
//   goes suspect and dead at once, then a pass over all slots with one more step per eviction, then a flush
// results leave on result_valid in the cycle after the step that produces them, scan events one
//   event later so the final one can be marked; no stall
// reset clears all slot valid bits at once and loads register defaults; no clearing pass
`include "peer_liveness_tracker_assert.svh"

module peer_liveness_tracker
    import plt_pkg::*;
#(
    parameter int PEER_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [21:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [3:0]  node_index,
    input  logic [15:0] cluster_tag,
    input  logic [31:0] endpoint_handle,
    input  logic [63:0] timestamp,
    output logic        result_valid,
    output logic [2:0]  evt_code,
    output logic [3:0]  peer_index,
    output logic [15:0] peer_cluster,
    output logic [1:0]  slot_status,
    output logic [63:0] event_time,
    output logic [63:0] last_heartbeat,
    output logic [63:0] state_changed,
    output logic [31:0] peer_endpoint,
    output logic        found,
    output logic        last_of_run
);

    localparam int AW = $clog2(PEER_SLOTS);
    localparam int RW = $bits(slot_rec_t);
    localparam logic [AW-1:0] LAST_SLOT = AW'(PEER_SLOTS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ONE   = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SAGE  = 4'd3;
    localparam logic [3:0] S_SEV   = 4'd4;
    localparam logic [3:0] S_SDEAD = 4'd5;
    localparam logic [3:0] S_ERD   = 4'd6;
    localparam logic [3:0] S_EOUT  = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  local_node_reg;
    logic [15:0] local_cluster_reg;
    logic [21:0] suspect_ms_reg, dead_ms_reg, evict_ms_reg;
    logic [41:0] sus_ns_reg, dead_ns_reg, evict_ns_reg;

    logic [1:0]  cmd_reg;
    logic [3:0]  idx_reg;
    logic [15:0] cl_reg;
    logic [31:0] ep_reg;
    logic [63:0] t_reg;

    logic [PEER_SLOTS-1:0] valid_reg, valid_next;
    logic [PEER_SLOTS-1:0] evict_reg, evict_next;
    logic [AW-1:0]         scan_reg, scan_next;
    slot_rec_t             rec_reg, rec_next;
    logic [63:0]           age_reg, age_next;

    result_t pend_reg, pend_next;
    logic    pend_valid_reg, pend_valid_next;
    result_t res_reg, res_next;
    logic    res_valid_reg, res_valid_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    slot_rec_t     ram_wdata, rd;
    logic [RW-1:0] ram_rdata;

    logic          in_range;
    logic [AW-1:0] idx_addr;
    logic          slot_vld;
    logic          push;
    result_t       push_res;
    result_t       ev_res;
    logic          sus_hit, dead_hit, evict_hit;
    logic [1:0]    st_a, st_b;

    plt_ram #(.WIDTH(RW), .DEPTH(PEER_SLOTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd       = slot_rec_t'(ram_rdata);
    assign in_range = {1'b0, idx_reg} < 5'(PEER_SLOTS);
    assign idx_addr = idx_reg[AW-1:0];
    assign slot_vld = in_range && valid_reg[idx_addr];
    assign busy     = state_reg != S_IDLE;

    // aging decisions for the slot held in rec_reg
    assign sus_hit   = (rec_reg.state == PS_ALIVE) && (age_reg >= {22'd0, sus_ns_reg});
    assign st_a      = sus_hit ? PS_SUSPECT : rec_reg.state;
    assign dead_hit  = (st_a == PS_SUSPECT) && (age_reg >= {22'd0, dead_ns_reg});
    assign st_b      = dead_hit ? PS_DEAD : st_a;
    assign evict_hit = (st_b == PS_DEAD) && (age_reg >= {22'd0, evict_ns_reg});

    always_comb
    begin
        ev_res           = '0;
        ev_res.index     = 4'(scan_reg);
        ev_res.cluster   = rec_reg.cluster;
        ev_res.time_ns   = t_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        evict_next      = evict_reg;
        scan_next       = scan_reg;
        rec_next        = rec_reg;
        age_next        = age_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        res_next        = res_reg;
        res_valid_next  = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = idx_addr;
        ram_wdata       = '0;
        ram_raddr       = scan_reg;
        push            = 1'b0;
        push_res        = ev_res;

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = node_index[AW-1:0];
                if (start)
                begin
                    scan_next  = '0;
                    state_next = (command == CMD_SCAN) ? S_SRD : S_ONE;
                end
            end
            S_ONE:
            begin
                state_next       = S_IDLE;
                res_next         = '0;
                res_next.index   = idx_reg;
                res_next.cluster = cl_reg;
                res_next.time_ns = t_reg;
                res_next.last    = 1'b1;
                res_next.kind    = EV_JOINED;
                case (cmd_reg)
                    CMD_HEARTBEAT:
                    begin
                        if (in_range && idx_reg != local_node_reg && cl_reg == local_cluster_reg)
                        begin
                            ram_we = 1'b1;
                            if (!slot_vld)
                            begin
                                ram_wdata           = '{PS_ALIVE, t_reg, t_reg, cl_reg, ep_reg};
                                valid_next[idx_addr] = 1'b1;
                                res_valid_next      = 1'b1;
                            end
                            else
                            begin
                                ram_wdata           = rd;
                                ram_wdata.state     = PS_ALIVE;
                                ram_wdata.last_beat = t_reg;
                                if (rd.state != PS_ALIVE)
                                begin
                                    ram_wdata.changed = t_reg;
                                end
                                if (ep_reg != '0)
                                begin
                                    ram_wdata.endpoint = ep_reg;
                                end
                            end
                        end
                    end
                    CMD_REGISTER:
                    begin
                        if (in_range && !slot_vld)
                        begin
                            ram_we               = 1'b1;
                            ram_wdata            = '{PS_ALIVE, t_reg, t_reg, cl_reg, ep_reg};
                            valid_next[idx_addr] = 1'b1;
                            res_valid_next       = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_valid_next   = 1'b1;
                        res_next.kind    = EV_QUERY;
                        res_next.time_ns = '0;
                        res_next.cluster = '0;
                        if (slot_vld)
                        begin
                            res_next.cluster   = rd.cluster;
                            res_next.state     = rd.state;
                            res_next.last_beat = rd.last_beat;
                            res_next.changed   = rd.changed;
                            res_next.endpoint  = rd.endpoint;
                            res_next.found     = 1'b1;
                        end
                    end
                endcase
            end
            S_SRD:
            begin
                if (valid_reg[scan_reg])
                begin
                    state_next = S_SAGE;
                end
                else if (scan_reg == LAST_SLOT)
                begin
                    scan_next  = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_SAGE:
            begin
                rec_next   = rd;
                age_next   = (t_reg > rd.last_beat) ? t_reg - rd.last_beat : '0;
                state_next = S_SEV;
            end
            S_SEV:
            begin
                ram_we          = 1'b1;
                ram_waddr       = scan_reg;
                ram_wdata       = rec_reg;
                ram_wdata.state = st_b;
                if (sus_hit || dead_hit)
                begin
                    ram_wdata.changed = t_reg;
                end
                evict_next[scan_reg] = evict_hit;
                if (sus_hit)
                begin
                    push           = 1'b1;
                    push_res.kind  = EV_SUSPECT;
                    push_res.state = PS_SUSPECT;
                end
                else if (dead_hit)
                begin
                    push           = 1'b1;
                    push_res.kind  = EV_DEAD;
                    push_res.state = PS_DEAD;
                end
                // a slot that turns suspect and dead in one scan needs a second step
                if (sus_hit && dead_hit)
                begin
                    state_next = S_SDEAD;
                end
                else if (scan_reg == LAST_SLOT)
                begin
                    scan_next  = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_SDEAD:
            begin
                push           = 1'b1;
                push_res.kind  = EV_DEAD;
                push_res.state = PS_DEAD;
                if (scan_reg == LAST_SLOT)
                begin
                    scan_next  = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_ERD:
            begin
                if (evict_reg[scan_reg])
                begin
                    state_next = S_EOUT;
                end
                else if (scan_reg == LAST_SLOT)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_EOUT:
            begin
                push                 = 1'b1;
                push_res.kind        = EV_EVICTED;
                push_res.state       = PS_DEAD;
                push_res.cluster     = rd.cluster;
                valid_next[scan_reg] = 1'b0;
                evict_next[scan_reg] = 1'b0;
                if (scan_reg == LAST_SLOT)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_ERD;
                end
            end
            S_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    res_valid_next  = 1'b1;
                    res_next        = pend_reg;
                    res_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // scan results wait one step so the final one can carry last_of_run
        if (push)
        begin
            if (pend_valid_reg)
            begin
                res_valid_next = 1'b1;
                res_next       = pend_reg;
            end
            pend_next       = push_res;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            valid_reg         <= '0;
            evict_reg         <= '0;
            pend_valid_reg    <= 1'b0;
            res_valid_reg     <= 1'b0;
            local_node_reg    <= '0;
            local_cluster_reg <= '0;
            suspect_ms_reg    <= SUSPECT_MS_RST;
            dead_ms_reg       <= DEAD_MS_RST;
            evict_ms_reg      <= EVICT_MS_RST;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            evict_reg      <= evict_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOCAL_NODE:    local_node_reg    <= cfg_data[3:0];
                    CFG_LOCAL_CLUSTER: local_cluster_reg <= cfg_data[15:0];
                    CFG_SUSPECT_MS:    suspect_ms_reg    <= cfg_data;
                    CFG_DEAD_MS:       dead_ms_reg       <= cfg_data;
                    CFG_EVICT_MS:      evict_ms_reg      <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sus_ns_reg   <= 42'(suspect_ms_reg) * 42'(NS_PER_MS);
        dead_ns_reg  <= 42'(dead_ms_reg) * 42'(NS_PER_MS);
        evict_ns_reg <= 42'(evict_ms_reg) * 42'(NS_PER_MS);
        scan_reg     <= scan_next;
        rec_reg      <= rec_next;
        age_reg      <= age_next;
        pend_reg     <= pend_next;
        res_reg      <= res_next;
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= command;
            idx_reg <= node_index;
            cl_reg  <= cluster_tag;
            ep_reg  <= endpoint_handle;
            t_reg   <= timestamp;
        end
    end

    assign result_valid   = res_valid_reg;
    assign evt_code       = res_reg.kind;
    assign peer_index     = res_reg.index;
    assign peer_cluster   = res_reg.cluster;
    assign slot_status    = res_reg.state;
    assign event_time     = res_reg.time_ns;
    assign last_heartbeat = res_reg.last_beat;
    assign state_changed  = res_reg.changed;
    assign peer_endpoint  = res_reg.endpoint;
    assign found          = res_reg.found;
    assign last_of_run    = res_reg.last;

    `PLT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `PLT_ASSERT_NOW(a_found_query, result_valid && found, evt_code == EV_QUERY)
    `PLT_ASSERT_NOW(a_idle_no_pend, state_reg == S_IDLE, !pend_valid_reg)
    `PLT_ASSERT_NOW(a_evict_only_valid, state_reg == S_EOUT, valid_reg[scan_reg])

endmodule
